### sv/bdf_pkg.sv
// ----------------------------------------------------------------------------
// bdf_pkg
// Types, character codes and format tables shared by the byte dump formatter.
// ----------------------------------------------------------------------------
package bdf_pkg;

  // command codes of an input item
  localparam logic [1:0] CMD_DATA  = 2'd0;
  localparam logic [1:0] CMD_FINAL = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;
  // spare code, behaves as end of stream
  localparam logic [1:0] CMD_RSVD  = 2'd3;

  // number bases
  localparam logic [1:0] BASE_OCT = 2'd0;
  localparam logic [1:0] BASE_DEC = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SELECT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_BYTES = 2'd1;

  // ascii codes
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_A     = 7'h41;
  localparam logic [6:0] CH_X     = 7'h78;
  localparam logic [6:0] CH_COMMA = 7'h2C;
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_NL    = 7'h0A;

  localparam int MAX_DIGITS = 11;

  typedef enum logic [1:0] {
    SEP_NONE,
    SEP_SPACE,
    SEP_BREAK
  } sep_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [6:0] text_char;
    logic       run_last;
    logic       stream_done;
  } out_item_t;

  // one queued print job, at most one per input item
  typedef struct packed {
    logic        has_val;
    sep_t        sep;
    logic [1:0]  base;
    logic [2:0]  count;
    logic [31:0] value;
    logic        end_nl;
  } job_t;

  // job with its digit characters ready, least significant digit at index 0
  typedef struct packed {
    logic                        has_val;
    sep_t                        sep;
    logic [1:0]                  base;
    logic [3:0]                  width;
    logic                        end_nl;
    logic [MAX_DIGITS-1:0][6:0]  chars;
  } render_t;

  function automatic logic [1:0] eff_base(input logic [1:0] sel);
    return (sel == 2'd3) ? BASE_HEX : sel;
  endfunction

  function automatic logic [2:0] eff_size(input logic [2:0] grp);
    logic [2:0] s;
    if (grp == 3'd0) begin
      s = 3'd1;
    end else if (grp > 3'd4) begin
      s = 3'd4;
    end else begin
      s = grp;
    end
    return s;
  endfunction

  // digits printed for a value of count bytes
  function automatic logic [3:0] digit_width(input logic [1:0] base, input logic [2:0] count);
    logic [3:0] w;
    case (base)
      BASE_OCT: begin
        case (count)
          3'd1:    w = 4'd3;
          3'd2:    w = 4'd6;
          3'd3:    w = 4'd8;
          default: w = 4'd11;
        endcase
      end
      BASE_DEC: begin
        case (count)
          3'd1:    w = 4'd3;
          3'd2:    w = 4'd5;
          3'd3:    w = 4'd8;
          default: w = 4'd10;
        endcase
      end
      default: begin
        case (count)
          3'd1:    w = 4'd2;
          3'd2:    w = 4'd4;
          3'd3:    w = 4'd6;
          default: w = 4'd8;
        endcase
      end
    endcase
    return w;
  endfunction

  // values per line
  function automatic logic [3:0] line_limit(input logic [1:0] base, input logic [2:0] size);
    logic [3:0] n;
    case (base)
      BASE_OCT: begin
        case (size)
          3'd1:    n = 4'd12;
          3'd2:    n = 4'd8;
          3'd3:    n = 4'd6;
          default: n = 4'd4;
        endcase
      end
      BASE_DEC: begin
        case (size)
          3'd1:    n = 4'd15;
          3'd2:    n = 4'd10;
          3'd3:    n = 4'd7;
          default: n = 4'd5;
        endcase
      end
      default: begin
        case (size)
          3'd1:    n = 4'd12;
          3'd2:    n = 4'd8;
          3'd3:    n = 4'd7;
          default: n = 4'd6;
        endcase
      end
    endcase
    return n;
  endfunction

endpackage

### sv/bdf_front.sv
// ----------------------------------------------------------------------------
// bdf_front
// Gathers bytes into groups, tracks the line column and queues one print job
// per input item that produces text.
// ----------------------------------------------------------------------------
module bdf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bdf_pkg::in_item_t in_item,
  input  logic [1:0]        base_eff,
  input  logic [2:0]        size_eff,
  input  logic              q_full,
  output logic              push,
  output bdf_pkg::job_t     push_job
);
  import bdf_pkg::*;

  logic [31:0] pv_r, pv_nxt, pv_shift;
  logic [1:0]  bg_r, bg_nxt, bg_kept;
  logic [3:0]  col_r, col_nxt, col_step, line_cap;
  logic [2:0]  gathered, count;
  logic        acc, is_data, is_end, full_grp, flush;
  sep_t        sep;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  always_comb begin
    is_data  = (in_item.cmd == CMD_DATA) || (in_item.cmd == CMD_FINAL);
    is_end   = (in_item.cmd != CMD_DATA);
    gathered = {1'b0, bg_r} + 3'd1;
    pv_shift = {pv_r[23:0], in_item.data_byte};
    full_grp = is_data && (gathered >= size_eff);
    bg_kept  = is_data ? gathered[1:0] : bg_r;
    // end of stream prints whatever is still gathered
    flush    = full_grp || (is_end && (bg_kept != 2'd0));
    count    = full_grp ? gathered : {1'b0, bg_kept};
    line_cap = line_limit(base_eff, size_eff);

    sep      = SEP_NONE;
    col_step = col_r;
    if (flush) begin
      if (col_r >= line_cap) begin
        sep      = SEP_BREAK;
        col_step = 4'd1;
      end else if (col_r == 4'd0) begin
        col_step = 4'd1;
      end else begin
        sep      = SEP_SPACE;
        col_step = col_r + 4'd1;
      end
    end

    push_job.has_val = flush;
    push_job.sep     = sep;
    push_job.base    = base_eff;
    push_job.count   = count;
    push_job.value   = is_data ? pv_shift : pv_r;
    push_job.end_nl  = is_end;
    push             = acc && (flush || is_end);

    if (is_end) begin
      pv_nxt  = '0;
      bg_nxt  = '0;
      col_nxt = '0;
    end else if (flush) begin
      pv_nxt  = '0;
      bg_nxt  = '0;
      col_nxt = col_step;
    end else begin
      pv_nxt  = pv_shift;
      bg_nxt  = bg_kept;
      col_nxt = col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r  <= '0;
      bg_r  <= '0;
      col_r <= '0;
    end else if (acc) begin
      pv_r  <= pv_nxt;
      bg_r  <= bg_nxt;
      col_r <= col_nxt;
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_item.cmd != CMD_DATA)) |=> (pv_r == '0 && bg_r == '0 && col_r == '0))
    else $error("stream end did not clear gather state");

  a_end_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_item.cmd != CMD_DATA)) |-> (push && push_job.end_nl))
    else $error("stream end item queued no newline");

endmodule

### sv/bdf_queue.sv
// ----------------------------------------------------------------------------
// bdf_queue
// Small job queue between the front and the back end.
// ----------------------------------------------------------------------------
module bdf_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bdf_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output bdf_pkg::job_t pop_job
);
  import bdf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_job   = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid)
    else $error("job queue underflow");

endmodule

### sv/bdf_conv.sv
// ----------------------------------------------------------------------------
// bdf_conv
// Turns a queued value into digit characters. Octal and hex digits are bit
// slices; decimal digits come one per cycle from a reciprocal multiply.
// ----------------------------------------------------------------------------
module bdf_conv (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  output logic             pop,
  input  bdf_pkg::job_t    pop_job,
  input  logic             take,
  output logic             rnd_valid,
  output bdf_pkg::render_t rnd
);
  import bdf_pkg::*;

  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

  logic        valid_r, done_r, free;
  render_t     work_r, load_rnd;
  logic [31:0] t_r, q10, rem;
  logic [3:0]  k_r, digit;
  logic [63:0] prod;
  logic [28:0] q;
  logic [43:0] v_ext;
  logic [2:0]  oct;
  logic [3:0]  nib;

  assign rnd_valid = valid_r && done_r;
  assign rnd       = work_r;
  assign free      = !valid_r || (done_r && take);
  assign pop       = free && pop_valid;

  // floor(t / 10) for any 32-bit t
  always_comb begin
    prod  = {32'd0, t_r} * {32'd0, RECIP10};
    q     = prod[63:35];
    q10   = {q, 3'b000} + {2'b00, q, 1'b0};
    rem   = t_r - q10;
    digit = rem[3:0];
  end

  always_comb begin
    v_ext            = {12'd0, pop_job.value};
    load_rnd.has_val = pop_job.has_val;
    load_rnd.sep     = pop_job.sep;
    load_rnd.base    = pop_job.base;
    load_rnd.width   = digit_width(pop_job.base, pop_job.count);
    load_rnd.end_nl  = pop_job.end_nl;
    for (int k = 0; k < MAX_DIGITS; k++) begin
      oct = v_ext[3*k +: 3];
      nib = v_ext[4*k +: 4];
      if (pop_job.base == BASE_DEC) begin
        // blanks; the digit loop overwrites all but the leading ones
        load_rnd.chars[k] = CH_SPACE;
      end else if (pop_job.base == BASE_OCT) begin
        load_rnd.chars[k] = CH_ZERO + {4'd0, oct};
      end else if (nib < 4'd10) begin
        load_rnd.chars[k] = CH_ZERO + {3'd0, nib};
      end else begin
        load_rnd.chars[k] = CH_A + {3'd0, nib} - 7'd10;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      done_r  <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
      done_r  <= !(pop_job.has_val && (pop_job.base == BASE_DEC));
    end else if (free) begin
      valid_r <= 1'b0;
    end else if (valid_r && !done_r) begin
      if ((q == '0) || (k_r == work_r.width - 4'd1)) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      work_r <= load_rnd;
      t_r    <= pop_job.value;
      k_r    <= '0;
    end else if (valid_r && !done_r) begin
      work_r.chars[k_r] <= CH_ZERO + {3'd0, digit};
      t_r               <= {3'b000, q};
      k_r               <= k_r + 4'd1;
    end
  end

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !done_r) |-> (k_r < work_r.width && rem < 32'd10))
    else $error("decimal digit step out of range");

endmodule

### sv/bdf_emit.sv
// ----------------------------------------------------------------------------
// bdf_emit
// Walks a rendered job character by character into the output register:
// separator, prefix, digits, closing newline.
// ----------------------------------------------------------------------------
module bdf_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rnd_valid,
  input  bdf_pkg::render_t   rnd,
  output logic               take,
  output logic               out_valid,
  input  logic               out_stall,
  output bdf_pkg::out_item_t out_item
);
  import bdf_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SEP0,
    PH_SEP1,
    PH_PRE0,
    PH_PRE1,
    PH_DIG,
    PH_NL
  } phase_t;

  phase_t    ph_r, ph_nxt, first_ph, val_start;
  render_t   job_r;
  logic [3:0] k_r;
  logic      out_valid_r, out_free, adv, last;
  out_item_t out_item_r;
  logic [6:0] ch;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign adv       = (ph_r != PH_IDLE) && out_free;

  always_comb begin
    val_start = (job_r.base == BASE_DEC) ? PH_DIG : PH_PRE0;
    case (ph_r)
      PH_SEP0: ch = CH_COMMA;
      PH_SEP1: ch = (job_r.sep == SEP_BREAK) ? CH_NL : CH_SPACE;
      PH_PRE0: ch = CH_ZERO;
      PH_PRE1: ch = CH_X;
      PH_DIG:  ch = job_r.chars[k_r];
      PH_NL:   ch = CH_NL;
      default: ch = CH_NL;
    endcase
    case (ph_r)
      PH_SEP0: ph_nxt = PH_SEP1;
      PH_SEP1: ph_nxt = val_start;
      PH_PRE0: ph_nxt = (job_r.base == BASE_HEX) ? PH_PRE1 : PH_DIG;
      PH_PRE1: ph_nxt = PH_DIG;
      PH_DIG: begin
        if (k_r != 4'd0) begin
          ph_nxt = PH_DIG;
        end else begin
          ph_nxt = job_r.end_nl ? PH_NL : PH_IDLE;
        end
      end
      default: ph_nxt = PH_IDLE;
    endcase
    last = (ph_nxt == PH_IDLE);

    if (rnd.sep != SEP_NONE) begin
      first_ph = PH_SEP0;
    end else if (!rnd.has_val) begin
      first_ph = PH_NL;
    end else if (rnd.base == BASE_DEC) begin
      first_ph = PH_DIG;
    end else begin
      first_ph = PH_PRE0;
    end
  end

  // next job loads as the last character of the current one goes out
  assign take = rnd_valid && ((ph_r == PH_IDLE) || (adv && last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        ph_r  <= first_ph;
        job_r <= rnd;
        k_r   <= rnd.width - 4'd1;
      end else if (adv) begin
        ph_r <= ph_nxt;
        if (ph_r == PH_DIG) begin
          k_r <= k_r - 4'd1;
        end
      end
      if (adv) begin
        out_valid_r            <= 1'b1;
        out_item_r.text_char   <= ch;
        out_item_r.run_last    <= last;
        out_item_r.stream_done <= (ph_r == PH_NL);
      end else if (out_free) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_done_is_last_nl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.stream_done) |->
      (out_item_r.run_last && out_item_r.text_char == CH_NL))
    else $error("stream end marker on wrong character");

endmodule

### sv/byte_dump_formatter.sv
// ----------------------------------------------------------------------------
// byte_dump_formatter
// Path: with the back end idle, the first character of an accepted item passes the
//   job queue, the converter and the emit phase to the output register; decimal
//   first runs its digit steps. Throughput: one character per cycle while out_stall
//   is low; an item produces 0 to 15 characters (6 for ", 0x41"); a decimal value whose
//   digit steps outlast the characters of the job ahead of it leaves idle output cycles.
// Reset: synchronous, clears gather state, queue and output; base hex, group one.
// ----------------------------------------------------------------------------
module byte_dump_formatter #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  bdf_pkg::in_item_t                in_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  output bdf_pkg::out_item_t               out_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bdf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bdf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bdf_pkg::*;

  logic [1:0] base_sel_r;
  logic [2:0] group_r;
  logic [1:0] base_eff;
  logic [2:0] size_eff;
  logic       q_full, push, pop, pop_valid, take, rnd_valid;
  job_t       push_job, pop_job;
  render_t    rnd;

  assign cfg_ready = 1'b1;
  assign base_eff  = eff_base(base_sel_r);
  assign size_eff  = eff_size(group_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_sel_r <= BASE_HEX;
      group_r    <= 3'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BASE_SELECT: base_sel_r <= cfg_data[1:0];
        CFG_GROUP_BYTES: group_r    <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  bdf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .base_eff (base_eff),
    .size_eff (size_eff),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  bdf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_job   (pop_job)
  );

  bdf_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_job   (pop_job),
    .take      (take),
    .rnd_valid (rnd_valid),
    .rnd       (rnd)
  );

  bdf_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .rnd_valid (rnd_valid),
    .rnd       (rnd),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: byte dump formatter testbench
// Drives byte streams and register writes into the formatter. A scoreboard
// works out the expected text characters and compares them with each
// character that leaves the block.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bdf_pkg::*;

  localparam int QUIET_CYCLES = 64;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int ITEM_TARGET  = 150;
  localparam int HOLD_PHASE   = 1;
  localparam int CALM_PHASE   = 2;

  // expected text of the dump plus its own copy of the formatter state
  class dump_scoreboard;
    out_item_t   chars_due[$];
    int          errors;
    int          pushed;
    logic [1:0]  base_sel;
    logic [2:0]  grp_sel;
    logic [31:0] acc;
    logic [1:0]  acc_bytes;
    logic [3:0]  column;
    int          digits_tab[3][5];
    int          line_cap_tab[3][5];

    function new();
      digits_tab   = '{'{0, 3, 6, 8, 11}, '{0, 3, 5, 8, 10}, '{0, 2, 4, 6, 8}};
      line_cap_tab = '{'{0, 12, 8, 6, 4}, '{0, 15, 10, 7, 5}, '{0, 12, 8, 7, 6}};
      errors    = 0;
      base_sel  = BASE_HEX;
      grp_sel   = 3'd1;
      acc       = '0;
      acc_bytes = '0;
      column    = '0;
    endfunction

    function void report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_BASE_SELECT) begin
        base_sel = data[1:0];
      end else if (idx == CFG_GROUP_BYTES) begin
        grp_sel = data[2:0];
      end
    endfunction

    function int base_now();
      return (base_sel > BASE_HEX) ? int'(BASE_HEX) : int'(base_sel);
    endfunction

    function int size_now();
      if (grp_sel == 3'd0) begin
        return 1;
      end
      if (grp_sel > 3'd4) begin
        return 4;
      end
      return int'(grp_sel);
    endfunction

    function void emit(logic [6:0] ch);
      out_item_t o;
      o.text_char   = ch;
      o.run_last    = 1'b0;
      o.stream_done = 1'b0;
      chars_due.push_back(o);
      pushed++;
    endfunction

    function void emit_value(int count);
      int          b;
      int          w;
      logic [3:0]  d;
      logic [31:0] t;
      logic [6:0]  digs[12];
      b = base_now();
      w = digits_tab[b][count];
      if (b == BASE_OCT) begin
        emit(CH_ZERO);
        for (int i = 0; i < w; i++) begin
          d = 4'((acc >> (3 * (w - 1 - i))) & 32'd7);
          emit(CH_ZERO + 7'(d));
        end
      end else if (b == BASE_DEC) begin
        // right aligned, leading spaces, a lone zero still prints
        t = acc;
        for (int i = w; i > 0; i--) begin
          if (i == w || t != 0) begin
            digs[i-1] = CH_ZERO + 7'(t % 10);
            t = t / 10;
          end else begin
            digs[i-1] = CH_SPACE;
          end
        end
        for (int i = 0; i < w; i++) begin
          emit(digs[i]);
        end
      end else begin
        emit(CH_ZERO);
        emit(CH_X);
        for (int i = 0; i < w; i++) begin
          d = 4'((acc >> (4 * (w - 1 - i))) & 32'd15);
          emit((d < 4'd10) ? CH_ZERO + 7'(d) : CH_A + 7'(d) - 7'd10);
        end
      end
    endfunction

    function void flush_group();
      int lim;
      int count;
      lim   = line_cap_tab[base_now()][size_now()];
      count = (acc_bytes == 2'd0) ? 4 : int'(acc_bytes);
      if (int'(column) >= lim) begin
        emit(CH_COMMA);
        emit(CH_NL);
        column = 4'd1;
      end else if (column == 4'd0) begin
        column = 4'd1;
      end else begin
        emit(CH_COMMA);
        emit(CH_SPACE);
        column = column + 4'd1;
      end
      emit_value(count);
      acc       = '0;
      acc_bytes = '0;
    endfunction

    function void note_item(in_item_t it);
      int gathered;
      int size;
      size   = size_now();
      pushed = 0;
      if (it.cmd == CMD_DATA || it.cmd == CMD_FINAL) begin
        gathered = int'(acc_bytes) + 1;
        acc = {acc[23:0], it.data_byte};
        if (gathered >= size) begin
          acc_bytes = (gathered >= 4) ? 2'd0 : 2'(gathered);
          flush_group();
        end else begin
          acc_bytes = 2'(gathered);
        end
        if (it.cmd == CMD_DATA) begin
          if (pushed > 0) begin
            chars_due[chars_due.size()-1].run_last = 1'b1;
          end
          return;
        end
      end
      // end of stream: final, end or the unused fourth command
      if (acc_bytes != 2'd0) begin
        flush_group();
      end
      emit(CH_NL);
      chars_due[chars_due.size()-1].run_last    = 1'b1;
      chars_due[chars_due.size()-1].stream_done = 1'b1;
      acc       = '0;
      acc_bytes = '0;
      column    = '0;
    endfunction

    function void check(out_item_t got);
      out_item_t want;
      if (chars_due.size() == 0) begin
        report($sformatf("unexpected char 0x%02h", got.text_char));
        return;
      end
      want = chars_due.pop_front();
      if (got.text_char !== want.text_char) begin
        report($sformatf("text_char 0x%02h, expected 0x%02h", got.text_char,
                         want.text_char));
      end
      if (got.run_last !== want.run_last) begin
        report($sformatf("run_last %b, expected %b on char 0x%02h", got.run_last,
                         want.run_last, want.text_char));
      end
      if (got.stream_done !== want.stream_done) begin
        report($sformatf("stream_done %b, expected %b on char 0x%02h",
                         got.stream_done, want.stream_done, want.text_char));
      end
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic calm      = 1'b0;
  logic hold_go   = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   cycles    = 0;
  int   items_sent = 0;

  dump_scoreboard sb;

  byte_dump_formatter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // text sink: checks each accepted char, stalls at random or for one long hold-off
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check(out_item);
    end
    if (hold_go && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 26);
    end
  end

  task automatic send(logic [1:0] cmd, logic [7:0] data);
    in_item_t it;
    int       gap;
    it.cmd       = cmd;
    it.data_byte = data;
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note_item(it);
    items_sent++;
    gap = 0;
    if (!calm) begin
      while ($urandom_range(99) < 26) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait for the text to run out, then let items without text settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.chars_due.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic send_stream(int len, bit leave_open);
    int r;
    for (int i = 0; i < len; i++) begin
      send(CMD_DATA, 8'($urandom));
    end
    if (leave_open) begin
      return;
    end
    r = $urandom_range(99);
    if (r < 50) begin
      send(CMD_FINAL, 8'($urandom));
    end else if (r < 90) begin
      send(CMD_END, 8'($urandom));
    end else begin
      send(CMD_RSVD, 8'($urandom));
    end
  endtask

  initial begin
    int phase;
    int grp;
    int r;
    int nstreams;
    int len;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config is hex, one byte: empty stream, extremes, unused command
    send(CMD_END, 8'h00);
    send(CMD_DATA, 8'h00);
    send(CMD_DATA, 8'hFF);
    send(CMD_FINAL, 8'hA5);
    send(CMD_RSVD, 8'hFF);
    // octal pairs, a short group at the end
    set_reg(CFG_BASE_SELECT, {6'h3F, BASE_OCT});
    set_reg(CFG_GROUP_BYTES, 8'd2);
    send(CMD_DATA, 8'hFF);
    send(CMD_DATA, 8'h00);
    send(CMD_FINAL, 8'h7F);
    // decimal words, widest value then a lone byte
    set_reg(CFG_BASE_SELECT, {6'h00, BASE_DEC});
    set_reg(CFG_GROUP_BYTES, 8'hFC);
    for (int i = 0; i < 4; i++) begin
      send(CMD_DATA, 8'hFF);
    end
    send(CMD_DATA, 8'h01);
    send(CMD_END, 8'h00);
    // base three and group size zero
    set_reg(CFG_BASE_SELECT, 8'd3);
    set_reg(CFG_GROUP_BYTES, 8'd0);
    send(CMD_DATA, 8'h00);
    send(CMD_FINAL, 8'hFF);
    // group size above four, octal
    set_reg(CFG_BASE_SELECT, {6'h15, BASE_OCT});
    set_reg(CFG_GROUP_BYTES, 8'd7);
    for (int i = 0; i < 4; i++) begin
      send(CMD_DATA, 8'h00);
    end
    send(CMD_FINAL, 8'h12);
    // three byte groups, then shrink the group with one byte pending
    set_reg(CFG_BASE_SELECT, {6'h2A, BASE_DEC});
    set_reg(CFG_GROUP_BYTES, 8'd3);
    send(CMD_DATA, 8'hFF);
    send(CMD_DATA, 8'hFF);
    send(CMD_DATA, 8'hFF);
    send(CMD_DATA, 8'h80);
    set_reg(CFG_GROUP_BYTES, 8'd1);
    send(CMD_DATA, 8'h3C);
    send(CMD_END, 8'h00);
    // indexes past the register list are ignored
    set_reg(2'd2, 8'($urandom));
    set_reg(2'd3, 8'($urandom));

    phase = 0;
    while (items_sent < ITEM_TARGET || phase < CALM_PHASE) begin
      phase++;
      r = $urandom_range(9);
      if (r < 3) begin
        grp = 1;
      end else if (r < 6) begin
        grp = 2;
      end else if (r < 8) begin
        grp = 4;
      end else if (r < 9) begin
        grp = 3;
      end else begin
        grp = $urandom_range(7);
      end
      set_reg(CFG_BASE_SELECT, 8'(($urandom_range(63) << 2) | $urandom_range(3)));
      set_reg(CFG_GROUP_BYTES, 8'(($urandom_range(31) << 3) | grp));
      calm <= (phase == CALM_PHASE);
      if (phase == HOLD_PHASE) begin
        // sink holds off while items keep coming, so the block backs up
        hold_go <= 1'b1;
      end
      nstreams = $urandom_range(1, 3);
      for (int s = 0; s < nstreams; s++) begin
        len = ($urandom_range(4) == 0) ? $urandom_range(20, 50) : $urandom_range(0, 14);
        // long first stream where the sink holds off or nobody idles
        if (s == 0 && (phase == HOLD_PHASE || phase == CALM_PHASE)) begin
          len = 40;
        end
        send_stream(len, (s == nstreams - 1) && ($urandom_range(9) == 0));
        if (phase != HOLD_PHASE && $urandom_range(3) == 0) begin
          drain();
        end
      end
    end
    calm <= 1'b0;
    send(CMD_END, 8'($urandom));

    drain();
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
